// ----- sv/rsx_pkg.sv -----
// Package: types and constants shared by the RV64 subset execute core.
`default_nettype none
package rsx_pkg;
    localparam logic [6:0] OP_R    = 7'b0110011;
    localparam logic [6:0] OP_I    = 7'b0010011;
    localparam logic [6:0] OP_B    = 7'b1100011;
    localparam logic [6:0] OP_L    = 7'b0000011;
    localparam logic [6:0] OP_S    = 7'b0100011;
    localparam logic [6:0] OP_JAL  = 7'b1101111;
    localparam logic [6:0] OP_JALR = 7'b1100111;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MUL  = 7'b0000001;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_EXEC  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_STOPPED = 3'd1;
    localparam logic [2:0] ST_ILLEGAL = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;
    localparam logic [1:0] MODE_FAULT = 2'd3;

    localparam logic [2:0] CFG_START_PC  = 3'd0;
    localparam logic [2:0] CFG_ARG_ZERO  = 3'd1;
    localparam logic [2:0] CFG_ARG_ONE   = 3'd2;
    localparam logic [2:0] CFG_ARG_TWO   = 3'd3;
    localparam logic [2:0] CFG_ARG_THREE = 3'd4;
    localparam logic [2:0] CFG_STOP_PC   = 3'd5;

    // operation classes decoded by the controller
    localparam logic [3:0] K_ALU    = 4'd0;
    localparam logic [3:0] K_MUL    = 4'd1;
    localparam logic [3:0] K_DIV    = 4'd2;
    localparam logic [3:0] K_BR     = 4'd3;
    localparam logic [3:0] K_LOAD   = 4'd4;
    localparam logic [3:0] K_STORE  = 4'd5;
    localparam logic [3:0] K_JAL    = 4'd6;
    localparam logic [3:0] K_JALR   = 4'd7;
    localparam logic [3:0] K_ILL    = 4'd8;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] instr_word;
        logic [2:0]  counter_select;
    } rsx_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] next_pc;
        logic [63:0] return_value;
        logic [31:0] counter_value;
    } rsx_out_t;

    // controller to datapath
    typedef struct packed {
        logic       start;     // apply start item
        logic       rd_a;      // read rs1 into operand register
        logic       rd_b;      // read rs2 into operand register
        logic       issue;     // evaluate decoded op (address, alu)
        logic       div_go;    // start divider
        logic       div_step;  // one divider or multiply step
        logic       mem_step;  // one byte of load/store
        logic       commit;    // write back and update pc
        logic       read_cnt;  // build counter read result
        logic       idle_res;  // result with status only
    } rsx_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       div_done;
        logic       mem_done;
        logic       range_err;
        logic       at_stop;
    } rsx_stat_t;
endpackage
`default_nettype wire

// ----- sv/riscv_subset_execute_core_unit.sv -----
// Top level of the RV64 subset execute core.
`default_nettype none
// One item at a time: in_stall is high while an item is in progress. Multiply
// sums three 32 by 32 partial products, divide and remainder use a 64-step
// restoring divider, loads go through the registered data memory read, and loads
// or stores out of range move no bytes. A result that is held off by out_stall
// holds the next instruction's commit, and a start waits until the previous
// transfer has gone. The data memory is not cleared: a load from a byte never
// stored returns undefined data.
module riscv_subset_execute_core_unit #(
    parameter int DMEM_BYTES = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire rsx_pkg::rsx_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output rsx_pkg::rsx_out_t      out_data,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [63:0]       cfg_data
);
    import rsx_pkg::*;
    rsx_cmd_t  cmd;
    rsx_stat_t stat;
    rsx_in_t   item;
    logic [3:0] kind;
    logic [2:0] status;

    rsx_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .cmd(cmd), .stat(stat), .item(item), .kind(kind), .status(status)
    );

    rsx_datapath #(.DMEM_BYTES(DMEM_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .item(item),
        .kind(kind), .status_in(status),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .res(out_data)
    );
endmodule
`default_nettype wire

// ----- sv/rsx_datapath.sv -----
// Datapath: register file, data memory, alu, multiplier, divider, counters and result register.
`default_nettype none
module rsx_datapath #(
    parameter int DMEM_BYTES = 4096
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rsx_pkg::rsx_cmd_t cmd,
    output rsx_pkg::rsx_stat_t    stat,
    input  wire rsx_pkg::rsx_in_t  item,
    input  wire logic [3:0]       kind,
    input  wire logic [2:0]       status_in,
    input  wire logic             cfg_we,
    input  wire logic [2:0]       cfg_idx,
    input  wire logic [63:0]      cfg_data,
    output rsx_pkg::rsx_out_t     res
);
    import rsx_pkg::*;
    localparam int AW = $clog2(DMEM_BYTES);

    logic [63:0] start_pc_reg, arg0_reg, arg1_reg, arg2_reg, arg3_reg, stop_pc_reg;
    logic [63:0] rf [32];
    logic [63:0] rf_a_reg, rf_b_reg;
    logic [63:0] pc_reg;
    logic [1:0]  mode_reg;
    logic [31:0] cnt_reg [7];
    logic [7:0]  mem [DMEM_BYTES];
    logic [7:0]  mem_q_reg;
    logic [63:0] val_reg;
    logic [63:0] addr_reg;
    logic [3:0]  size_reg;
    logic [3:0]  bidx_reg;
    logic        range_reg;
    logic        mem_rd_pend_reg;
    logic [63:0] quo_reg, rem_reg, dvs_reg;
    logic [6:0]  dcnt_reg;
    logic        neg_q_reg, neg_r_reg, dzero_reg;
    logic [2:0]  rstat_reg;
    logic [31:0] rcnt_reg;

    logic [31:0] iw;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [63:0] imm_i, imm_s, imm_b, imm_j;
    logic [63:0] alu_v;
    logic        take;
    logic [63:0] ea;
    logic [3:0]  sz;
    logic [64:0] rtry;
    logic [63:0] pc_new;
    logic [63:0] wb_v;
    logic        wb_en;
    logic [63:0] load_ext;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;

    assign iw  = item.instr_word;
    assign rd  = iw[11:7];
    assign rs1 = iw[19:15];
    assign rs2 = iw[24:20];
    assign f3  = iw[14:12];
    assign imm_i = {{52{iw[31]}}, iw[31:20]};
    assign imm_s = {{52{iw[31]}}, iw[31:25], iw[11:7]};
    assign imm_b = {{51{iw[31]}}, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
    assign imm_j = {{43{iw[31]}}, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0};

    always_comb
    begin
        alu_v = 64'd0;
        if (iw[6:0] == OP_R)
        begin
            case (f3)
                3'd0:    alu_v = (iw[31:25] == F7_ALT) ? rf_a_reg - rf_b_reg
                                                       : rf_a_reg + rf_b_reg;
                3'd1:    alu_v = rf_a_reg << rf_b_reg[5:0];
                3'd5:    alu_v = rf_a_reg >> rf_b_reg[5:0];
                3'd7:    alu_v = rf_a_reg & rf_b_reg;
                default: alu_v = 64'd0;
            endcase
        end
        else
        begin
            case (f3)
                3'd0:    alu_v = rf_a_reg + imm_i;
                3'd1:    alu_v = rf_a_reg << iw[25:20];
                3'd5:    alu_v = rf_a_reg >> iw[25:20];
                default: alu_v = 64'd0;
            endcase
        end
    end

    always_comb
    begin
        case (f3)
            3'd0:    take = rf_a_reg == rf_b_reg;
            3'd1:    take = rf_a_reg != rf_b_reg;
            3'd4:    take = $signed(rf_a_reg) < $signed(rf_b_reg);
            default: take = !($signed(rf_a_reg) < $signed(rf_b_reg));
        endcase
    end

    always_comb
    begin
        case (f3)
            3'd0:    sz = 4'd1;
            3'd2:    sz = 4'd4;
            default: sz = 4'd8;
        endcase
    end
    assign ea = rf_a_reg + ((kind == K_STORE) ? imm_s : imm_i);

    assign rtry = {rem_reg, quo_reg[63]} - {1'b0, dvs_reg};

    // one 32 by 32 partial product a step: lo*lo, lo*hi, hi*lo
    assign mul_x = (dcnt_reg[1:0] == 2'd2) ? rf_a_reg[63:32] : rf_a_reg[31:0];
    assign mul_y = (dcnt_reg[1:0] == 2'd1) ? rf_b_reg[63:32] : rf_b_reg[31:0];
    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

    always_comb
    begin
        case (size_reg)
            4'd1:    load_ext = {{56{val_reg[7]}}, val_reg[7:0]};
            4'd4:    load_ext = {{32{val_reg[31]}}, val_reg[31:0]};
            default: load_ext = val_reg;
        endcase
    end

    always_comb
    begin
        pc_new = pc_reg + 64'd4;
        wb_en  = 1'b0;
        wb_v   = 64'd0;
        case (kind)
            K_ALU:
            begin
                wb_en = 1'b1;
                wb_v  = alu_v;
            end
            K_MUL:
            begin
                wb_en = 1'b1;
                wb_v  = quo_reg;
            end
            K_DIV:
            begin
                wb_en = 1'b1;
                if (dzero_reg)
                    wb_v = f3[1] ? rf_a_reg : 64'hFFFF_FFFF_FFFF_FFFF;
                else if (f3[1])
                    wb_v = neg_r_reg ? 64'd0 - rem_reg : rem_reg;
                else
                    wb_v = neg_q_reg ? 64'd0 - quo_reg : quo_reg;
            end
            K_BR:
                if (take)
                    pc_new = pc_reg + imm_b;
            K_LOAD:
            begin
                wb_en = 1'b1;
                wb_v  = load_ext;
            end
            K_JAL:
            begin
                wb_en  = 1'b1;
                wb_v   = pc_reg + 64'd4;
                pc_new = pc_reg + imm_j;
            end
            K_JALR:
            begin
                wb_en  = 1'b1;
                wb_v   = pc_reg + 64'd4;
                pc_new = (rf_a_reg + imm_i) & ~64'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg <= 64'd0;
            arg0_reg     <= 64'd0;
            arg1_reg     <= 64'd0;
            arg2_reg     <= 64'd0;
            arg3_reg     <= 64'd0;
            stop_pc_reg  <= 64'd0;
            rf_a_reg     <= 64'd0;
            rf_b_reg     <= 64'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_START_PC:  start_pc_reg <= cfg_data;
                    CFG_ARG_ZERO:  arg0_reg     <= cfg_data;
                    CFG_ARG_ONE:   arg1_reg     <= cfg_data;
                    CFG_ARG_TWO:   arg2_reg     <= cfg_data;
                    CFG_ARG_THREE: arg3_reg     <= cfg_data;
                    CFG_STOP_PC:   stop_pc_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.rd_a)
                rf_a_reg <= (rs1 == 5'd0) ? 64'd0 : rf[rs1];
            if (cmd.rd_b)
                rf_b_reg <= (rs2 == 5'd0) ? 64'd0 : rf[rs2];
        end
    end

    // register file, pc, mode and counters with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                rf[i] <= 64'd0;
            pc_reg   <= 64'd0;
            mode_reg <= MODE_IDLE;
            for (int i = 0; i < 7; i++)
                cnt_reg[i] <= 32'd0;
        end
        else if (cmd.start)
        begin
            pc_reg <= start_pc_reg;
            rf[10] <= arg0_reg;
            rf[11] <= arg1_reg;
            rf[12] <= arg2_reg;
            rf[13] <= arg3_reg;
            rf[1]  <= stop_pc_reg;
            rf[2]  <= 64'(DMEM_BYTES);
            for (int i = 0; i < 7; i++)
                cnt_reg[i] <= 32'd0;
            mode_reg <= (start_pc_reg == stop_pc_reg) ? MODE_STOP : MODE_RUN;
        end
        else if (cmd.commit)
        begin
            if (kind == K_ILL)
                mode_reg <= MODE_FAULT;
            else if ((kind == K_LOAD || kind == K_STORE) && range_reg)
                mode_reg <= MODE_FAULT;
            else
            begin
                if (wb_en && rd != 5'd0)
                    rf[rd] <= wb_v;
                pc_reg <= pc_new;
                if (pc_new == stop_pc_reg)
                    mode_reg <= MODE_STOP;
                if (cnt_reg[0] != 32'hFFFF_FFFF)
                    cnt_reg[0] <= cnt_reg[0] + 32'd1;
                case (kind)
                    K_ALU, K_MUL, K_DIV:
                        if (cnt_reg[1] != 32'hFFFF_FFFF)
                            cnt_reg[1] <= cnt_reg[1] + 32'd1;
                    K_LOAD:
                        if (cnt_reg[2] != 32'hFFFF_FFFF)
                            cnt_reg[2] <= cnt_reg[2] + 32'd1;
                    K_STORE:
                        if (cnt_reg[3] != 32'hFFFF_FFFF)
                            cnt_reg[3] <= cnt_reg[3] + 32'd1;
                    K_JAL, K_JALR:
                        if (cnt_reg[4] != 32'hFFFF_FFFF)
                            cnt_reg[4] <= cnt_reg[4] + 32'd1;
                    K_BR:
                        if (take)
                        begin
                            if (cnt_reg[5] != 32'hFFFF_FFFF)
                                cnt_reg[5] <= cnt_reg[5] + 32'd1;
                        end
                        else if (cnt_reg[6] != 32'hFFFF_FFFF)
                            cnt_reg[6] <= cnt_reg[6] + 32'd1;
                    default: ;
                endcase
            end
        end
    end

    // address check, load/store byte sequencing
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            addr_reg  <= ea;
            size_reg  <= sz;
            bidx_reg  <= 4'd0;
            range_reg <= (ea > 64'(DMEM_BYTES) - {60'd0, sz});
            val_reg   <= 64'd0;
            mem_rd_pend_reg <= 1'b0;
        end
        else if (cmd.mem_step)
        begin
            if (kind == K_STORE)
            begin
                mem[addr_reg[AW-1:0]] <= rf_b_reg[8*bidx_reg[2:0] +: 8];
                addr_reg <= addr_reg + 64'd1;
                bidx_reg <= bidx_reg + 4'd1;
            end
            else
            begin
                mem_q_reg <= mem[addr_reg[AW-1:0]];
                mem_rd_pend_reg <= 1'b1;
                if (mem_rd_pend_reg)
                begin
                    val_reg[8*bidx_reg[2:0] +: 8] <= mem_q_reg;
                    bidx_reg <= bidx_reg + 4'd1;
                end
                addr_reg <= addr_reg + 64'd1;
            end
        end
    end

    // restoring divider on magnitudes, one quotient bit a cycle;
    // multiply accumulates three partial products in quo_reg
    always_ff @(posedge clk)
    begin
        if (cmd.div_go)
        begin
            if (kind == K_MUL)
                quo_reg <= 64'd0;
            else
                quo_reg <= rf_a_reg[63] ? 64'd0 - rf_a_reg : rf_a_reg;
            dvs_reg   <= rf_b_reg[63] ? 64'd0 - rf_b_reg : rf_b_reg;
            rem_reg   <= 64'd0;
            dcnt_reg  <= 7'd0;
            neg_q_reg <= rf_a_reg[63] ^ rf_b_reg[63];
            neg_r_reg <= rf_a_reg[63];
            dzero_reg <= rf_b_reg == 64'd0;
        end
        else if (cmd.div_step)
        begin
            if (kind == K_MUL)
                quo_reg <= quo_reg + ((dcnt_reg == 7'd0) ? mul_p : {mul_p[31:0], 32'd0});
            else if (!rtry[64])
            begin
                rem_reg <= rtry[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit || cmd.read_cnt || cmd.idle_res)
        begin
            rstat_reg <= status_in;
            rcnt_reg  <= (cmd.read_cnt && item.req_type == REQ_READ &&
                          item.counter_select != 3'd7) ? cnt_reg[item.counter_select] : 32'd0;
        end
    end

    // pc and a0 are read live: they only change on commit or start
    always_comb
    begin
        res.status        = rstat_reg;
        res.next_pc       = pc_reg;
        res.return_value  = rf[10];
        res.counter_value = rcnt_reg;
    end

    assign stat.mode      = mode_reg;
    assign stat.div_done  = dcnt_reg == ((kind == K_MUL) ? 7'd3 : 7'd64);
    assign stat.mem_done  = bidx_reg == size_reg;
    assign stat.range_err = range_reg;
    assign stat.at_stop   = pc_new == stop_pc_reg;

    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_go |=> dcnt_reg == 7'd0) else $error("divider not cleared");
    a_no_step_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.div_step && cmd.mem_step)) else $error("divider and memory both stepped");
    a_start_mode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (mode_reg == MODE_RUN || mode_reg == MODE_STOP))
        else $error("start left bad mode");
endmodule
`default_nettype wire

// ----- sv/rsx_ctrl.sv -----
// Controller: handshake, decode and sequencing of each item.
`default_nettype none
module rsx_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire rsx_pkg::rsx_in_t  in_item,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output rsx_pkg::rsx_cmd_t      cmd,
    input  wire rsx_pkg::rsx_stat_t stat,
    output rsx_pkg::rsx_in_t       item,
    output logic [3:0]             kind,
    output logic [2:0]             status
);
    import rsx_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EX   = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MEM  = 3'd4;
    localparam logic [2:0] S_CMT  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    rsx_in_t    item_reg;
    logic       ov_reg, ov_next;
    logic [3:0] kind_c;
    logic [6:0] op, f7;
    logic [2:0] f3;
    logic       accept;

    assign op = item_reg.instr_word[6:0];
    assign f3 = item_reg.instr_word[14:12];
    assign f7 = item_reg.instr_word[31:25];

    always_comb
    begin
        kind_c = K_ILL;
        case (op)
            OP_R:
                if (f7 == 7'd0 && (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd5 || f3 == 3'd7))
                    kind_c = K_ALU;
                else if (f7 == F7_ALT && f3 == 3'd0)
                    kind_c = K_ALU;
                else if (f7 == F7_MUL && f3 == 3'd0)
                    kind_c = K_MUL;
                else if (f7 == F7_MUL && (f3 == 3'd4 || f3 == 3'd6))
                    kind_c = K_DIV;
            OP_I:
                if (f3 == 3'd0 ||
                    ((f3 == 3'd1 || f3 == 3'd5) && item_reg.instr_word[31:26] == 6'd0))
                    kind_c = K_ALU;
            OP_B:
                if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd4 || f3 == 3'd5)
                    kind_c = K_BR;
            OP_L:
                if (f3 == 3'd0 || f3 == 3'd2 || f3 == 3'd3)
                    kind_c = K_LOAD;
            OP_S:
                if (f3 == 3'd0 || f3 == 3'd2 || f3 == 3'd3)
                    kind_c = K_STORE;
            OP_JAL:  kind_c = K_JAL;
            OP_JALR: if (f3 == 3'd0) kind_c = K_JALR;
            default: kind_c = K_ILL;
        endcase
    end

    assign accept = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        status     = ST_OK;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_RD;
            S_RD:
            begin
                if (item_reg.req_type == REQ_START)
                begin
                    // pc and a0 feed the waiting transfer, so hold start until it leaves
                    if (!ov_reg || !out_stall)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_CMT;
                    end
                end
                else if (item_reg.req_type == REQ_EXEC && stat.mode == MODE_RUN)
                begin
                    cmd.rd_a   = 1'b1;
                    cmd.rd_b   = 1'b1;
                    state_next = S_EX;
                end
                else
                    state_next = S_CMT;
            end
            S_EX:
            begin
                cmd.issue = 1'b1;
                cmd.div_go = kind_c == K_DIV || kind_c == K_MUL;
                if (kind_c == K_DIV || kind_c == K_MUL)
                    state_next = S_DIV;
                else if (kind_c == K_LOAD || kind_c == K_STORE)
                    state_next = S_MEM;
                else
                    state_next = S_CMT;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_CMT;
                else
                    cmd.div_step = 1'b1;
            end
            S_MEM:
            begin
                if (stat.range_err || stat.mem_done)
                    state_next = S_CMT;
                else
                    cmd.mem_step = 1'b1;
            end
            S_CMT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    if (item_reg.req_type == REQ_START)
                    begin
                        cmd.idle_res = 1'b1;
                        status = (stat.mode == MODE_STOP) ? ST_STOPPED : ST_OK;
                    end
                    else if (item_reg.req_type == REQ_EXEC)
                    begin
                        if (stat.mode != MODE_RUN)
                        begin
                            cmd.idle_res = 1'b1;
                            status = ST_IDLE;
                        end
                        else
                        begin
                            cmd.commit = 1'b1;
                            if (kind_c == K_ILL)
                                status = ST_ILLEGAL;
                            else if ((kind_c == K_LOAD || kind_c == K_STORE) && stat.range_err)
                                status = ST_RANGE;
                            else if (stat.at_stop)
                                status = ST_STOPPED;
                        end
                    end
                    else
                    begin
                        cmd.read_cnt = 1'b1;
                        status = (stat.mode == MODE_RUN) ? ST_OK :
                                 (stat.mode == MODE_STOP) ? ST_STOPPED : ST_IDLE;
                    end
                    ov_next    = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
    end

    assign out_valid = ov_reg;
    assign item      = item_reg;
    assign kind      = kind_c;

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.commit, cmd.read_cnt, cmd.idle_res}))
        else $error("more than one result command");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg) else $error("result dropped");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_RD) else $error("accept out of idle");
endmodule
`default_nettype wire
